// ----- hdl/guj_pkg.sv -----
// ----------------------------------------------------------------------------
// guj_pkg
// Shared types and constants of the grouped undo journal.
// ----------------------------------------------------------------------------
package guj_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int LINE_BITS_DEF     = 16;

  localparam int TAG_W    = 32;
  localparam int KIND_W   = 2;
  localparam int TEXT_W   = 32;
  localparam int CURSOR_W = 16;
  localparam int LINE_W   = 16;

  typedef enum logic [1:0] {
    ACT_NEW_STEP = 2'd0,
    ACT_RECORD   = 2'd1,
    ACT_UNDO     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_CHANGED  = 2'd0,
    KIND_INSERTED = 2'd1,
    KIND_DELETED  = 2'd2
  } edit_kind_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [KIND_W-1:0]   edit_kind;
    logic [LINE_W-1:0]   line_number;
    logic [TEXT_W-1:0]   saved_text_handle;
    logic [CURSOR_W-1:0] cursor_row_in;
    logic [CURSOR_W-1:0] cursor_col_in;
  } in_word_t;

  typedef struct packed {
    logic                performed;
    logic [KIND_W-1:0]   undo_kind;
    logic [LINE_W-1:0]   undo_line;
    logic [TEXT_W-1:0]   restore_text_handle;
    logic [CURSOR_W-1:0] restore_row;
    logic [CURSOR_W-1:0] restore_col;
    logic                last_of_step;
  } out_word_t;

  // shift control for the cell row: push moves toward the bottom, pop toward the top
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- hdl/guj_in_if.sv -----
// ----------------------------------------------------------------------------
// guj_in_if
// Input channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
interface guj_in_if;
  logic              valid;
  logic              ready;
  guj_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/guj_out_if.sv -----
// ----------------------------------------------------------------------------
// guj_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface guj_out_if;
  logic               valid;
  logic               ready;
  guj_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/guj_cell.sv -----
// ----------------------------------------------------------------------------
// guj_cell
// One journal slot. Takes its upper neighbor on push, its lower one on pop.
// ----------------------------------------------------------------------------
module guj_cell #(
  parameter int ENTRY_W = 128
) (
  input  logic                clk,
  input  guj_pkg::cell_ctl_t  ctl,
  input  logic [ENTRY_W-1:0]  upper_in,
  input  logic [ENTRY_W-1:0]  lower_in,
  output logic [ENTRY_W-1:0]  entry_o
);
  import guj_pkg::*;

  logic [ENTRY_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r <= upper_in;
    end else if (ctl.pop) begin
      entry_r <= lower_in;
    end
  end

  assign entry_o = entry_r;

endmodule

// ----- hdl/grouped_undo_journal.sv -----
// ----------------------------------------------------------------------------
// grouped_undo_journal
// Bounded undo journal held in a row of shifting cells, top of stack in cell 0.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  in_w    | in  | valid & ready        | action, edit kind, line, text, cursor
//  out_w   | out | valid & ready        | one popped record per word
//
//  Step and record words leave the journal idle; the row shifts on every push.
//  An undo pops the records of the top step: one cell pops per cycle,
//  gated by the output register; an empty journal gives one word.
//  in_w.ready is low while an undo is popping; output stalls hold the pop.
//  Synchronous reset empties the journal and zeroes the step counter.
// ----------------------------------------------------------------------------
module grouped_undo_journal #(
  parameter int HISTORY_DEPTH = guj_pkg::HISTORY_DEPTH_DEF,
  parameter int LINE_BITS     = guj_pkg::LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  guj_in_if.sink    in_w,
  guj_out_if.source out_w
);
  import guj_pkg::*;

  // entry layout: {tag, kind, line, text, row, col}
  localparam int COL_LO  = 0;
  localparam int ROW_LO  = COL_LO + CURSOR_W;
  localparam int TEXT_LO = ROW_LO + CURSOR_W;
  localparam int LINE_LO = TEXT_LO + TEXT_W;
  localparam int KIND_LO = LINE_LO + LINE_BITS;
  localparam int TAG_LO  = KIND_LO + KIND_W;
  localparam int ENTRY_W = TAG_LO + TAG_W;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [TAG_W-1:0]    step_r;
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic [ENTRY_W-1:0]  entry [HISTORY_DEPTH];
  logic [ENTRY_W-1:0]  new_entry;
  cell_ctl_t           ctl;

  logic                in_fire;
  logic                kind_ok;
  logic                push;
  logic                pop;
  logic                out_free;
  logic                full;
  logic                last;
  logic [TEXT_W-1:0]   new_text;

  assign in_fire  = in_w.valid && in_w.ready;
  assign kind_ok  = in_w.data.edit_kind inside {KIND_CHANGED, KIND_INSERTED, KIND_DELETED};
  assign push     = in_fire && (in_w.data.action == ACT_RECORD) && kind_ok;
  assign out_free = !out_valid_r || out_w.ready;
  assign pop      = (state_r == S_POP) && out_free && (count_r != '0);
  assign full     = (count_r == CNT_W'(HISTORY_DEPTH));

  assign new_text  = (in_w.data.edit_kind == KIND_INSERTED) ? '0
                                                            : in_w.data.saved_text_handle;
  assign new_entry = {step_r,
                      in_w.data.edit_kind,
                      LINE_BITS'(in_w.data.line_number),
                      new_text,
                      in_w.data.cursor_row_in,
                      in_w.data.cursor_col_in};

  assign ctl.push = push;
  assign ctl.pop  = pop;

  // top record closes the step when it is the only record or the record below it has another tag
  assign last = (count_r == CNT_W'(1)) ||
                (entry[1][TAG_LO +: TAG_W] != entry[0][TAG_LO +: TAG_W]);

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] upper;
    logic [ENTRY_W-1:0] lower;
    if (i == 0) begin : g_top
      assign upper = new_entry;
    end else begin : g_mid_up
      assign upper = entry[i-1];
    end
    if (i == HISTORY_DEPTH - 1) begin : g_bottom
      assign lower = entry[i];
    end else begin : g_mid_dn
      assign lower = entry[i+1];
    end
    guj_cell #(.ENTRY_W(ENTRY_W)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .upper_in (upper),
      .lower_in (lower),
      .entry_o  (entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (in_fire && (in_w.data.action == ACT_NEW_STEP)) begin
        step_r <= step_r + TAG_W'(1);
      end
      if (push && !full) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop) begin
        count_r <= count_r - CNT_W'(1);
      end
      // a new word loads whenever the popping side finds the register free
      if ((state_r == S_POP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_w.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && (in_w.data.action == ACT_UNDO)) begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          if (out_free) begin
            if (count_r == '0) begin
              out_data_r <= '0;
              state_r    <= S_IDLE;
            end else begin
              out_data_r.performed           <= 1'b1;
              out_data_r.undo_kind           <= entry[0][KIND_LO +: KIND_W];
              out_data_r.undo_line           <= LINE_W'(entry[0][LINE_LO +: LINE_BITS]);
              out_data_r.restore_text_handle <= entry[0][TEXT_LO +: TEXT_W];
              out_data_r.restore_row         <= entry[0][ROW_LO +: CURSOR_W];
              out_data_r.restore_col         <= entry[0][COL_LO +: CURSOR_W];
              out_data_r.last_of_step        <= last;
              if (last) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_w.ready = (state_r == S_IDLE);
  assign out_w.valid = out_valid_r;
  assign out_w.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HISTORY_DEPTH))
    else $error("journal count above depth");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_data_r.performed && !out_data_r.last_of_step
      |-> state_r == S_POP)
    else $error("undo ended before last record of step");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.performed |-> out_data_r == '0)
    else $error("empty undo word carries data");
`endif

endmodule
